[rtl/core/srp_pkg.sv]
// shared types and constants for the socks5 request parser
package srp_pkg;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_CMD     = 4'd1,
        PH_RSV     = 4'd2,
        PH_ATYP    = 4'd3,
        PH_IPV4    = 4'd4,
        PH_HOSTLEN = 4'd5,
        PH_HOST    = 4'd6,
        PH_IPV6    = 4'd7,
        PH_PORT    = 4'd8
    } phase_t;

    typedef enum logic [3:0] {
        KIND_VER     = 4'd0,
        KIND_CMD     = 4'd1,
        KIND_RSV     = 4'd2,
        KIND_ATYP    = 4'd3,
        KIND_IPV4    = 4'd4,
        KIND_HOSTLEN = 4'd5,
        KIND_HOST    = 4'd6,
        KIND_IPV6    = 4'd7,
        KIND_PORT    = 4'd8,
        KIND_STRAY   = 4'd9
    } kind_t;

    localparam logic [7:0] ATYP_IPV4   = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN = 8'h03;
    localparam logic [7:0] ATYP_IPV6   = 8'h04;

    localparam logic [7:0] IPV4_LEN = 8'd4;
    localparam logic [7:0] IPV6_LEN = 8'd16;
    localparam logic [7:0] PORT_LEN = 8'd2;

    localparam logic [8:0] COUNT_MAX = 9'd511;

    localparam int TDATA_W = 56;
    localparam int TUSER_W = 5;

    typedef struct packed {
        kind_t       byte_kind;
        logic [7:0]  byte_value;
        logic [7:0]  field_offset;
        logic        request_done;
        logic [8:0]  request_length;
        logic [7:0]  command_code;
        logic [15:0] port_number;
        logic        type_error;
    } result_t;

endpackage

[rtl/core/socks5_request_parser.sv]
// top level of the socks5 request parser
//
// usage:
//   s_axis carries one request byte per beat: tdata[7:0] is the byte, tuser
//   set marks the version byte of a new request and restarts the parser.
//   m_axis returns one beat per input beat: the byte tagged with its role
//   (tuser[3:0]), its offset within the address, host or port field, and
//   the running length, command and port; tlast is high on the final port
//   byte of a complete request. tuser[4] flags an unknown address type.
//   output: the tagged result of an accepted byte is registered in the result
//   register, or in the skid entry while the result register is held by a stall.
//   throughput: one byte per cycle while the skid entry is empty; the parser
//   state is updated in the accepting cycle, so back-to-back bytes need no gap.
//   stall: a two-entry output stage (result register plus skid) holds
//   results; s_axis_tready drops only once the skid entry is full, and
//   nothing is lost or repeated.
//   reset: rst_n clears the parser to idle and empties the output stage;
//   bytes arriving before a start byte are tagged stray.
module socks5_request_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] byte_value, [15:8] field_offset, [24:16] request_length,
    // [32:25] command_code, [48:33] port_number, [55:49] zero
    output logic [srp_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [srp_pkg::TUSER_W-1:0] m_axis_tuser,  // [3:0] byte_kind, [4] type_error
    output logic        m_axis_tlast    // request_done
);

    srp_pkg::result_t parse_res;
    srp_pkg::result_t out_res;
    logic             accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    srp_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (accept),
        .data_byte   (s_axis_tdata),
        .frame_start (s_axis_tuser),
        .result      (parse_res)
    );

    srp_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (parse_res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    assign m_axis_tdata = {7'd0, out_res.port_number, out_res.command_code,
                           out_res.request_length, out_res.field_offset,
                           out_res.byte_value};
    assign m_axis_tuser = {out_res.type_error, out_res.byte_kind};
    assign m_axis_tlast = out_res.request_done;

endmodule

[rtl/core/srp_parse.sv]
// byte tagging state machine: parser state and per-beat result logic
module srp_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [7:0]        data_byte,
    input  logic              frame_start,
    output srp_pkg::result_t  result
);

    srp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [7:0]  host_total_reg, host_total_next;
    logic [8:0]  byte_count_reg, byte_count_next;
    logic [7:0]  held_command_reg, held_command_next;
    logic [15:0] port_accum_reg, port_accum_next;
    logic        error_seen_reg, error_seen_next;

    logic [7:0]      left_dec;
    srp_pkg::kind_t  kind;
    logic [7:0]      offs;
    logic            done;

    assign left_dec = bytes_left_reg - 8'd1;

    // next state
    always_comb
    begin
        phase_next        = phase_reg;
        bytes_left_next   = bytes_left_reg;
        host_total_next   = host_total_reg;
        byte_count_next   = byte_count_reg;
        held_command_next = held_command_reg;
        port_accum_next   = port_accum_reg;
        error_seen_next   = error_seen_reg;
        if (frame_start)
        begin
            phase_next        = srp_pkg::PH_CMD;
            bytes_left_next   = 8'd0;
            host_total_next   = 8'd0;
            byte_count_next   = 9'd1;
            held_command_next = 8'd0;
            port_accum_next   = 16'd0;
            error_seen_next   = 1'b0;
        end
        else if (phase_reg != srp_pkg::PH_IDLE)
        begin
            if (byte_count_reg != srp_pkg::COUNT_MAX)
            begin
                byte_count_next = byte_count_reg + 9'd1;
            end
            unique case (phase_reg)
                srp_pkg::PH_CMD:
                begin
                    held_command_next = data_byte;
                    phase_next        = srp_pkg::PH_RSV;
                end
                srp_pkg::PH_RSV:
                begin
                    phase_next = srp_pkg::PH_ATYP;
                end
                srp_pkg::PH_ATYP:
                begin
                    priority if (data_byte == srp_pkg::ATYP_IPV4)
                    begin
                        bytes_left_next = srp_pkg::IPV4_LEN;
                        phase_next      = srp_pkg::PH_IPV4;
                    end
                    else if (data_byte == srp_pkg::ATYP_IPV6)
                    begin
                        bytes_left_next = srp_pkg::IPV6_LEN;
                        phase_next      = srp_pkg::PH_IPV6;
                    end
                    else if (data_byte == srp_pkg::ATYP_DOMAIN)
                    begin
                        phase_next = srp_pkg::PH_HOSTLEN;
                    end
                    else
                    begin
                        error_seen_next = 1'b1;
                        phase_next      = srp_pkg::PH_IDLE;
                    end
                end
                srp_pkg::PH_IPV4, srp_pkg::PH_IPV6, srp_pkg::PH_HOST:
                begin
                    bytes_left_next = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        bytes_left_next = srp_pkg::PORT_LEN;
                        phase_next      = srp_pkg::PH_PORT;
                    end
                end
                srp_pkg::PH_HOSTLEN:
                begin
                    host_total_next = data_byte;
                    if (data_byte == 8'd0)
                    begin
                        bytes_left_next = srp_pkg::PORT_LEN;
                        phase_next      = srp_pkg::PH_PORT;
                    end
                    else
                    begin
                        bytes_left_next = data_byte;
                        phase_next      = srp_pkg::PH_HOST;
                    end
                end
                srp_pkg::PH_PORT:
                begin
                    port_accum_next = {port_accum_reg[7:0], data_byte};
                    bytes_left_next = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        phase_next = srp_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = srp_pkg::PH_IDLE;
                end
            endcase
        end
        else
        begin
            phase_next = srp_pkg::PH_IDLE;
        end
    end

    // per-beat tag, offset and completion
    always_comb
    begin
        kind = srp_pkg::KIND_STRAY;
        offs = 8'd0;
        done = 1'b0;
        if (frame_start)
        begin
            kind = srp_pkg::KIND_VER;
        end
        else
        begin
            unique case (phase_reg)
                srp_pkg::PH_CMD:     kind = srp_pkg::KIND_CMD;
                srp_pkg::PH_RSV:     kind = srp_pkg::KIND_RSV;
                srp_pkg::PH_ATYP:    kind = srp_pkg::KIND_ATYP;
                srp_pkg::PH_HOSTLEN: kind = srp_pkg::KIND_HOSTLEN;
                srp_pkg::PH_IPV4:
                begin
                    kind = srp_pkg::KIND_IPV4;
                    offs = srp_pkg::IPV4_LEN - bytes_left_reg;
                end
                srp_pkg::PH_IPV6:
                begin
                    kind = srp_pkg::KIND_IPV6;
                    offs = srp_pkg::IPV6_LEN - bytes_left_reg;
                end
                srp_pkg::PH_HOST:
                begin
                    kind = srp_pkg::KIND_HOST;
                    offs = host_total_reg - bytes_left_reg;
                end
                srp_pkg::PH_PORT:
                begin
                    kind = srp_pkg::KIND_PORT;
                    offs = srp_pkg::PORT_LEN - bytes_left_reg;
                    done = (left_dec == 8'd0);
                end
                default:             kind = srp_pkg::KIND_STRAY;
            endcase
        end
    end

    assign result.byte_kind      = kind;
    assign result.byte_value     = data_byte;
    assign result.field_offset   = offs;
    assign result.request_done   = done;
    assign result.request_length = byte_count_next;
    assign result.command_code   = held_command_next;
    assign result.port_number    = port_accum_next;
    assign result.type_error     = error_seen_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= srp_pkg::PH_IDLE;
            bytes_left_reg   <= 8'd0;
            host_total_reg   <= 8'd0;
            byte_count_reg   <= 9'd0;
            held_command_reg <= 8'd0;
            port_accum_reg   <= 16'd0;
            error_seen_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            bytes_left_reg   <= bytes_left_next;
            host_total_reg   <= host_total_next;
            byte_count_reg   <= byte_count_next;
            held_command_reg <= held_command_next;
            port_accum_reg   <= port_accum_next;
            error_seen_reg   <= error_seen_next;
        end
    end

    // a completed request always leaves the parser idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result.request_done) |=> (phase_reg == srp_pkg::PH_IDLE))
        else $error("parser not idle after completed request");

    // a type error never coincides with completion of the same request
    assert property (@(posedge clk) disable iff (!rst_n)
        result.request_done |-> !result.type_error)
        else $error("completion reported with a type error");

endmodule

[rtl/core/srp_obuf.sv]
// result register with skid stage between parser and output channel
module srp_obuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  srp_pkg::result_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output srp_pkg::result_t  out_data
);

    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    srp_pkg::result_t main_data_reg, main_data_next;
    srp_pkg::result_t skid_data_reg, skid_data_next;
    logic             push;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (!main_valid_reg || out_ready)
        begin
            main_valid_next = skid_valid_reg || push;
            main_data_next  = skid_valid_reg ? skid_data_reg : in_data;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    // skid stage only fills behind an occupied result register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid stage full while result register empty");

    // a waiting skid beat moves to the output as soon as the output drains
    assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (main_valid_reg && !skid_valid_reg
            && (main_data_reg == $past(skid_data_reg))))
        else $error("skid beat lost or reordered");

endmodule

[tb/testbench.sv]
// testbench for the socks5 request parser: predicted results checked beat by beat
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 6;
    localparam int MAX_REPORTS = 10;

    // receiver behavior
    localparam int RX_ALWAYS = 0;
    localparam int RX_RANDOM = 1;
    localparam int RX_PATTERN = 2;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [srp_pkg::TDATA_W-1:0] m_axis_tdata;
    logic [srp_pkg::TUSER_W-1:0] m_axis_tuser;
    logic m_axis_tlast;

    socks5_request_parser uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // parser state as the testbench sees it
    srp_pkg::phase_t pr_phase;
    logic [7:0]  pr_addr_type;
    logic [7:0]  pr_remaining;
    logic [7:0]  pr_host_len;
    logic [8:0]  pr_length;
    logic [7:0]  pr_command;
    logic [15:0] pr_port;
    logic        pr_type_err;

    srp_pkg::result_t expected_beats[$];

    int cycles;
    int mismatches;
    int bytes_sent;
    int beats_checked;
    int requests_done;
    int type_errors;
    int stray_bytes;
    int longest_request;

    bit gap_on;
    int burst_left;
    int rx_mode;
    logic [15:0] rx_pat;
    int hold_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycles,
                     expected_beats.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: a long hold-off takes priority over the current stall mode
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
        begin
            case (rx_mode)
                RX_ALWAYS: m_axis_tready <= 1'b1;
                RX_RANDOM: m_axis_tready <= ($urandom_range(0, 99) < 65);
                default:
                begin
                    m_axis_tready <= rx_pat[0];
                    rx_pat = {rx_pat[0], rx_pat[15:1]};
                end
            endcase
        end
    end

    function automatic string fmt_beat(srp_pkg::result_t r);
        return $sformatf({"kind=%0d val=%02h off=%0d done=%0b ",
                          "len=%0d cmd=%02h port=%04h err=%0b"},
                         r.byte_kind, r.byte_value, r.field_offset, r.request_done,
                         r.request_length, r.command_code, r.port_number, r.type_error);
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    // work out the tagged beat for one accepted request byte
    task automatic parse_byte(input logic [7:0] b, input logic start);
        srp_pkg::result_t r;
        r.byte_kind = srp_pkg::KIND_STRAY;
        r.byte_value = b;
        r.field_offset = 8'd0;
        r.request_done = 1'b0;
        if (start)
        begin
            r.byte_kind = srp_pkg::KIND_VER;
            pr_length = 9'd1;
            pr_command = 8'd0;
            pr_port = 16'd0;
            pr_type_err = 1'b0;
            pr_addr_type = 8'd0;
            pr_remaining = 8'd0;
            pr_host_len = 8'd0;
            pr_phase = srp_pkg::PH_CMD;
        end
        else if (pr_phase != srp_pkg::PH_IDLE)
        begin
            if (pr_length != srp_pkg::COUNT_MAX)
                pr_length = pr_length + 9'd1;
            case (pr_phase)
                srp_pkg::PH_CMD:
                begin
                    r.byte_kind = srp_pkg::KIND_CMD;
                    pr_command = b;
                    pr_phase = srp_pkg::PH_RSV;
                end
                srp_pkg::PH_RSV:
                begin
                    r.byte_kind = srp_pkg::KIND_RSV;
                    pr_phase = srp_pkg::PH_ATYP;
                end
                srp_pkg::PH_ATYP:
                begin
                    r.byte_kind = srp_pkg::KIND_ATYP;
                    pr_addr_type = b;
                    if (b == srp_pkg::ATYP_IPV4)
                    begin
                        pr_remaining = srp_pkg::IPV4_LEN;
                        pr_phase = srp_pkg::PH_IPV4;
                    end
                    else if (b == srp_pkg::ATYP_IPV6)
                    begin
                        pr_remaining = srp_pkg::IPV6_LEN;
                        pr_phase = srp_pkg::PH_IPV6;
                    end
                    else if (b == srp_pkg::ATYP_DOMAIN)
                        pr_phase = srp_pkg::PH_HOSTLEN;
                    else
                    begin
                        pr_type_err = 1'b1;
                        pr_phase = srp_pkg::PH_IDLE;
                    end
                end
                srp_pkg::PH_IPV4, srp_pkg::PH_IPV6:
                begin
                    r.byte_kind = (pr_phase == srp_pkg::PH_IPV4) ? srp_pkg::KIND_IPV4
                                                                 : srp_pkg::KIND_IPV6;
                    r.field_offset = ((pr_phase == srp_pkg::PH_IPV4) ? srp_pkg::IPV4_LEN
                                                                     : srp_pkg::IPV6_LEN)
                                     - pr_remaining;
                    pr_remaining = pr_remaining - 8'd1;
                    if (pr_remaining == 8'd0)
                    begin
                        pr_remaining = srp_pkg::PORT_LEN;
                        pr_phase = srp_pkg::PH_PORT;
                    end
                end
                srp_pkg::PH_HOSTLEN:
                begin
                    r.byte_kind = srp_pkg::KIND_HOSTLEN;
                    pr_host_len = b;
                    // empty host name goes straight to the port
                    if (b == 8'd0)
                    begin
                        pr_remaining = srp_pkg::PORT_LEN;
                        pr_phase = srp_pkg::PH_PORT;
                    end
                    else
                    begin
                        pr_remaining = b;
                        pr_phase = srp_pkg::PH_HOST;
                    end
                end
                srp_pkg::PH_HOST:
                begin
                    r.byte_kind = srp_pkg::KIND_HOST;
                    r.field_offset = pr_host_len - pr_remaining;
                    pr_remaining = pr_remaining - 8'd1;
                    if (pr_remaining == 8'd0)
                    begin
                        pr_remaining = srp_pkg::PORT_LEN;
                        pr_phase = srp_pkg::PH_PORT;
                    end
                end
                default:
                begin
                    r.byte_kind = srp_pkg::KIND_PORT;
                    r.field_offset = srp_pkg::PORT_LEN - pr_remaining;
                    pr_port = {pr_port[7:0], b};
                    pr_remaining = pr_remaining - 8'd1;
                    if (pr_remaining == 8'd0)
                    begin
                        r.request_done = 1'b1;
                        pr_phase = srp_pkg::PH_IDLE;
                    end
                end
            endcase
        end
        r.request_length = pr_length;
        r.command_code = pr_command;
        r.port_number = pr_port;
        r.type_error = pr_type_err;
        expected_beats.push_back(r);
    endtask

    // output check first, then prediction for the byte taken at this edge
    always @(posedge clk or negedge rst_n)
    begin
        srp_pkg::result_t got;
        srp_pkg::result_t want;
        if (!rst_n)
        begin
            pr_phase = srp_pkg::PH_IDLE;
            pr_addr_type = 8'd0;
            pr_remaining = 8'd0;
            pr_host_len = 8'd0;
            pr_length = 9'd0;
            pr_command = 8'd0;
            pr_port = 16'd0;
            pr_type_err = 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.byte_kind = srp_pkg::kind_t'(m_axis_tuser[3:0]);
                got.type_error = m_axis_tuser[4];
                got.byte_value = m_axis_tdata[7:0];
                got.field_offset = m_axis_tdata[15:8];
                got.request_length = m_axis_tdata[24:16];
                got.command_code = m_axis_tdata[32:25];
                got.port_number = m_axis_tdata[48:33];
                got.request_done = m_axis_tlast;
                if (expected_beats.size() == 0)
                    flag_mismatch({"unexpected beat ", fmt_beat(got)});
                else
                begin
                    want = expected_beats.pop_front();
                    beats_checked++;
                    if (got !== want)
                        flag_mismatch({"expected ", fmt_beat(want), " got ", fmt_beat(got)});
                    if (m_axis_tdata[srp_pkg::TDATA_W-1:49] !== '0)
                        flag_mismatch($sformatf("tdata padding not zero: %h",
                                                m_axis_tdata[srp_pkg::TDATA_W-1:49]));
                    if (want.request_done)
                    begin
                        requests_done++;
                        if (int'(want.request_length) > longest_request)
                            longest_request = int'(want.request_length);
                    end
                    if (want.byte_kind == srp_pkg::KIND_ATYP && want.type_error)
                        type_errors++;
                    if (want.byte_kind == srp_pkg::KIND_STRAY)
                        stray_bytes++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                parse_byte(s_axis_tdata, s_axis_tuser);
        end
    end

    // offer one byte and hold it until taken; bursts and gaps when enabled
    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        if (gap_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= start;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // stop offering and let every outstanding beat come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one request with random content; cut short at a random byte if asked
    task automatic send_request(input logic [7:0] atyp, input int host_len,
                                input bit truncate);
        logic [7:0] seq[$];
        int n;
        int i;
        seq.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h05);
        seq.push_back(8'($urandom));
        seq.push_back(8'($urandom));
        seq.push_back(atyp);
        if (atyp == srp_pkg::ATYP_IPV4 || atyp == srp_pkg::ATYP_IPV6
            || atyp == srp_pkg::ATYP_DOMAIN)
        begin
            if (atyp == srp_pkg::ATYP_DOMAIN)
                seq.push_back(8'(host_len));
            n = (atyp == srp_pkg::ATYP_IPV4) ? 4 : (atyp == srp_pkg::ATYP_IPV6) ? 16 : host_len;
            for (i = 0; i < n; i++)
                seq.push_back(8'($urandom));
            seq.push_back(8'($urandom));
            seq.push_back(8'($urandom));
        end
        n = truncate ? $urandom_range(1, seq.size() - 1) : seq.size();
        for (i = 0; i < n; i++)
            send_byte(seq[i], i == 0);
    endtask

    task automatic test_directed_cases();
        gap_on = 1'b0;
        rx_mode = RX_ALWAYS;
        send_byte(8'hFF, 1'b0);         // stray before any start
        send_byte(8'h05, 1'b1);         // abandoned by the restart below
        send_byte(8'h02, 1'b0);
        send_byte(8'h05, 1'b1);         // ipv4, all-ones address and port
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(srp_pkg::ATYP_IPV4, 1'b0);
        repeat (6) send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);         // stray after completion
        send_byte(8'h05, 1'b1);         // domain with empty host, zero port
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(srp_pkg::ATYP_DOMAIN, 1'b0);
        repeat (3) send_byte(8'h00, 1'b0);
        send_byte(8'h05, 1'b1);         // unknown address type
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);         // stray after the type error
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_bytes, input bit gaps, input int rx);
        int target;
        int pick;
        int hlen;
        logic [7:0] atyp;
        gap_on = gaps;
        rx_mode = rx;
        rx_pat = 16'($urandom_range(1, 16'hFFFF));
        target = bytes_sent + n_bytes;
        while (bytes_sent < target)
        begin
            pick = $urandom_range(0, 99);
            hlen = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64)
                                                : $urandom_range(0, 12);
            case ($urandom_range(0, 2))
                0: atyp = srp_pkg::ATYP_IPV4;
                1: atyp = srp_pkg::ATYP_DOMAIN;
                default: atyp = srp_pkg::ATYP_IPV6;
            endcase
            if (pick < 70)
                send_request(atyp, hlen, 1'b0);
            else if (pick < 80)
                send_request(atyp, hlen, 1'b1);
            else if (pick < 88)
            begin
                atyp = 8'($urandom);
                while (atyp == srp_pkg::ATYP_IPV4 || atyp == srp_pkg::ATYP_IPV6
                       || atyp == srp_pkg::ATYP_DOMAIN)
                    atyp = 8'($urandom);
                send_request(atyp, 0, 1'b0);
            end
            else
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
        end
        wait_drained();
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_output_holdoff();
        gap_on = 1'b0;
        rx_mode = RX_ALWAYS;
        hold_cycles = 120;
        repeat (3) send_request(srp_pkg::ATYP_IPV4, 0, 1'b0);
        send_request(srp_pkg::ATYP_DOMAIN, 5, 1'b0);
        wait_drained();
    endtask

    // longest host name: offsets up to 254 and the longest request length
    task automatic test_longest_host();
        gap_on = 1'b1;
        rx_mode = RX_RANDOM;
        send_request(srp_pkg::ATYP_DOMAIN, 255, 1'b0);
        send_request(srp_pkg::ATYP_DOMAIN, 1, 1'b0);
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'd0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        cycles = 0;
        mismatches = 0;
        bytes_sent = 0;
        beats_checked = 0;
        requests_done = 0;
        type_errors = 0;
        stray_bytes = 0;
        longest_request = 0;
        gap_on = 1'b0;
        burst_left = 0;
        rx_mode = RX_ALWAYS;
        rx_pat = 16'h5A5A;
        hold_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_traffic(100, 1'b0, RX_ALWAYS);
        test_random_traffic(100, 1'b1, RX_RANDOM);
        test_output_holdoff();
        test_random_traffic(90, 1'b0, RX_PATTERN);
        test_random_traffic(90, 1'b1, RX_PATTERN);
        test_longest_host();
        test_random_traffic(90, 1'b1, RX_ALWAYS);
        test_random_traffic(90, 1'b0, RX_RANDOM);

        if (expected_beats.size() != 0)
            flag_mismatch($sformatf("%0d beats never arrived", expected_beats.size()));
        $display("summary: %0d bytes in, %0d beats checked, %0d requests completed",
                 bytes_sent, beats_checked, requests_done);
        $display("summary: %0d bad address types, %0d stray bytes, longest request %0d bytes",
                 type_errors, stray_bytes, longest_request);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
